// ----- hw/rtl/qea_pkg.sv -----
// shared types, constants and micro-op programs of the quadric error accumulator
`timescale 1ns / 1ps

package qea_pkg;

	// field widths
	localparam int CMD_W    = 3;
	localparam int PLANE_W  = 18;
	localparam int WEIGHT_W = 24;
	localparam int POINT_W  = 18;
	localparam int SCALE_W  = 18;
	localparam int MUL_B_W  = 18;
	localparam int ERR_W    = 48;
	localparam int SUM_W    = 32;

	// coefficient store and sequencer
	localparam int NUM_COEFF = 10;
	localparam int IDX_W     = 4;
	localparam int STEP_W    = 4;

	localparam logic [STEP_W-1:0] PLANE_LAST = 4'd9;
	localparam logic [STEP_W-1:0] SCALE_LAST = 4'd9;
	localparam logic [STEP_W-1:0] EVAL_LAST  = 4'd12;

	// plane operand pairs of the ten outer-product terms
	localparam logic [1:0] PLANE_IA [NUM_COEFF] = '{
		2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3
	};
	localparam logic [1:0] PLANE_IB [NUM_COEFF] = '{
		2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3
	};

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_SUB   = 3'd2,
		CMD_SCALE = 3'd3,
		CMD_EVAL  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// multiplier operand a source
	typedef enum logic [1:0] {
		ASEL_COEF,
		ASEL_PLANE,
		ASEL_ACC
	} asel_t;

	// multiplier operand b source
	typedef enum logic [2:0] {
		BSEL_X,
		BSEL_Y,
		BSEL_Z,
		BSEL_ONE,
		BSEL_SCALE,
		BSEL_PLANE
	} bsel_t;

	// partial sum registers
	typedef enum logic [1:0] {
		ACC_X,
		ACC_Y,
		ACC_Z
	} acc_t;

	// one micro-op: multiply, register the product, then shift, saturate and accumulate
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] rd_idx;
		asel_t            asel;
		logic [1:0]       a_pln;
		acc_t             a_acc;
		bsel_t            bsel;
		logic [1:0]       b_pln;
		logic             shift;
		logic             neg;
		logic             dbl;
		logic             load;
		logic             to_coef;
		acc_t             dst;
		logic             wgt_add;
		logic             wgt_sub;
	} op_t;

	// controller to datapath
	typedef struct packed {
		op_t  op;
		logic load_item;
		logic clear;
		logic out_load;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

	// add or subtract one outer-product term of the plane
	function automatic op_t plane_op(input logic [STEP_W-1:0] step, input logic sub);
		op_t op;
		op         = '0;
		op.vld     = 1'b1;
		op.rd_idx  = step;
		op.asel    = ASEL_PLANE;
		op.a_pln   = PLANE_IA[step];
		op.bsel    = BSEL_PLANE;
		op.b_pln   = PLANE_IB[step];
		op.neg     = sub;
		op.to_coef = 1'b1;
		op.wgt_add = (step == '0) && !sub;
		op.wgt_sub = (step == '0) && sub;
		return op;
	endfunction

	// scale one coefficient in place
	function automatic op_t scale_op(input logic [STEP_W-1:0] step);
		op_t op;
		op         = '0;
		op.vld     = 1'b1;
		op.rd_idx  = step;
		op.asel    = ASEL_COEF;
		op.bsel    = BSEL_SCALE;
		op.shift   = 1'b1;
		op.load    = 1'b1;
		op.to_coef = 1'b1;
		return op;
	endfunction

	// point evaluation: px, py, pz partial sums, then the error into ACC_X
	function automatic op_t eval_op(input logic [STEP_W-1:0] step);
		op_t op;
		op       = '0;
		op.vld   = 1'b1;
		op.shift = 1'b1;
		op.asel  = ASEL_COEF;
		case (step)
			4'd0: begin
				op.rd_idx = 4'd0; op.bsel = BSEL_X; op.load = 1'b1; op.dst = ACC_X;
			end
			4'd1: begin
				op.rd_idx = 4'd1; op.bsel = BSEL_Y; op.dbl = 1'b1; op.dst = ACC_X;
			end
			4'd2: begin
				op.rd_idx = 4'd2; op.bsel = BSEL_Z; op.dbl = 1'b1; op.dst = ACC_X;
			end
			4'd3: begin
				op.rd_idx = 4'd3; op.bsel = BSEL_ONE; op.dbl = 1'b1; op.dst = ACC_X;
			end
			4'd4: begin
				op.rd_idx = 4'd4; op.bsel = BSEL_Y; op.load = 1'b1; op.dst = ACC_Y;
			end
			4'd5: begin
				op.rd_idx = 4'd5; op.bsel = BSEL_Z; op.dbl = 1'b1; op.dst = ACC_Y;
			end
			4'd6: begin
				op.rd_idx = 4'd6; op.bsel = BSEL_ONE; op.dbl = 1'b1; op.dst = ACC_Y;
			end
			4'd7: begin
				op.rd_idx = 4'd7; op.bsel = BSEL_Z; op.load = 1'b1; op.dst = ACC_Z;
			end
			4'd8: begin
				op.rd_idx = 4'd8; op.bsel = BSEL_ONE; op.dbl = 1'b1; op.dst = ACC_Z;
			end
			4'd9: begin
				op.asel = ASEL_ACC; op.a_acc = ACC_X; op.bsel = BSEL_X;
				op.load = 1'b1; op.dst = ACC_X;
			end
			4'd10: begin
				op.asel = ASEL_ACC; op.a_acc = ACC_Y; op.bsel = BSEL_Y; op.dst = ACC_X;
			end
			4'd11: begin
				op.asel = ASEL_ACC; op.a_acc = ACC_Z; op.bsel = BSEL_Z; op.dst = ACC_X;
			end
			4'd12: begin
				op.rd_idx = 4'd9; op.bsel = BSEL_ONE; op.dst = ACC_X;
			end
			default: begin
				op = '0;
			end
		endcase
		return op;
	endfunction

endpackage

// ----- hw/rtl/qea_if.sv -----
// command and result channel interfaces of the quadric error accumulator
`timescale 1ns / 1ps

interface qea_in_if;
	logic                                 valid;
	logic                                 ready;
	logic        [qea_pkg::CMD_W-1:0]    command;
	logic signed [qea_pkg::PLANE_W-1:0]  plane_a;
	logic signed [qea_pkg::PLANE_W-1:0]  plane_b;
	logic signed [qea_pkg::PLANE_W-1:0]  plane_c;
	logic signed [qea_pkg::PLANE_W-1:0]  plane_d;
	logic signed [qea_pkg::WEIGHT_W-1:0] plane_weight;
	logic signed [qea_pkg::POINT_W-1:0]  point_x;
	logic signed [qea_pkg::POINT_W-1:0]  point_y;
	logic signed [qea_pkg::POINT_W-1:0]  point_z;
	logic signed [qea_pkg::SCALE_W-1:0]  scale_factor;

	modport source (
		output valid, command, plane_a, plane_b, plane_c, plane_d, plane_weight,
		output point_x, point_y, point_z, scale_factor,
		input  ready
	);
	modport sink (
		input  valid, command, plane_a, plane_b, plane_c, plane_d, plane_weight,
		input  point_x, point_y, point_z, scale_factor,
		output ready
	);
endinterface

interface qea_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [qea_pkg::ERR_W-1:0] error_value;
	logic signed [qea_pkg::SUM_W-1:0] weight_sum;

	modport source (
		output valid, error_value, weight_sum,
		input  ready
	);
	modport sink (
		input  valid, error_value, weight_sum,
		output ready
	);
endinterface

// ----- hw/rtl/quadric_error_accumulator.sv -----
// top level of the quadric error accumulator: sequencer plus datapath
// evaluate: steps RUN, DRAIN and FINISH; the result is registered on leaving FINISH, then the next item is taken
// add, subtract and scale plane: one shared multiplier, 10 steps, then DRAIN before the next item
// clear and unknown commands do not start the sequencer; an evaluate also waits while the last result is held
// reset clears the ten coefficients, the weight total and all control state
`timescale 1ns / 1ps

module quadric_error_accumulator #(
	parameter int FRAC_BITS   = 12,
	parameter int COEFF_WIDTH = 48
) (
	input logic        clk,
	input logic        arst_n,
	qea_in_if.sink     cmd,
	qea_out_if.source  result
);

	qea_pkg::ctl_t ctl;
	qea_pkg::sts_t sts;

	// sequencer
	qea_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd.valid),
		.in_command (cmd.command),
		.in_ready   (cmd.ready),
		.ctl        (ctl),
		.sts        (sts)
	);

	// datapath
	qea_dp #(
		.FRAC_BITS   (FRAC_BITS),
		.COEFF_WIDTH (COEFF_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.plane_a      (cmd.plane_a),
		.plane_b      (cmd.plane_b),
		.plane_c      (cmd.plane_c),
		.plane_d      (cmd.plane_d),
		.plane_weight (cmd.plane_weight),
		.point_x      (cmd.point_x),
		.point_y      (cmd.point_y),
		.point_z      (cmd.point_z),
		.scale_factor (cmd.scale_factor),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.error_value  (result.error_value),
		.weight_sum   (result.weight_sum)
	);

endmodule

// ----- hw/rtl/qea_ctrl.sv -----
// sequencer that steps the micro-op programs of the quadric error accumulator
`timescale 1ns / 1ps

module qea_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [qea_pkg::CMD_W-1:0]   in_command,
	output logic                        in_ready,
	output qea_pkg::ctl_t               ctl,
	input  qea_pkg::sts_t               sts
);

	qea_pkg::state_t                  state_q, state_d;
	qea_pkg::cmd_t                    cmd_q;
	logic [qea_pkg::STEP_W-1:0]       step_q;
	logic [qea_pkg::STEP_W-1:0]       last_step;
	logic                             accept;
	logic                             start;

	assign accept = in_valid && in_ready;

	// commands that need the sequencer
	always_comb begin
		case (qea_pkg::cmd_t'(in_command))
			qea_pkg::CMD_ADD, qea_pkg::CMD_SUB, qea_pkg::CMD_SCALE, qea_pkg::CMD_EVAL: begin
				start = 1'b1;
			end
			default: begin
				start = 1'b0;
			end
		endcase
	end

	// program length
	always_comb begin
		case (cmd_q)
			qea_pkg::CMD_EVAL:  last_step = qea_pkg::EVAL_LAST;
			qea_pkg::CMD_SCALE: last_step = qea_pkg::SCALE_LAST;
			default:            last_step = qea_pkg::PLANE_LAST;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qea_pkg::ST_IDLE;
			cmd_q   <= qea_pkg::CMD_CLEAR;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept && start) begin
				cmd_q <= qea_pkg::cmd_t'(in_command);
			end
			if (state_q == qea_pkg::ST_RUN) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctl      = '0;
		case (state_q)
			qea_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load_item = 1'b1;
					ctl.clear     = (in_command == qea_pkg::CMD_CLEAR);
					if (start) begin
						state_d = qea_pkg::ST_RUN;
					end
				end
			end
			qea_pkg::ST_RUN: begin
				case (cmd_q)
					qea_pkg::CMD_ADD:   ctl.op = qea_pkg::plane_op(step_q, 1'b0);
					qea_pkg::CMD_SUB:   ctl.op = qea_pkg::plane_op(step_q, 1'b1);
					qea_pkg::CMD_SCALE: ctl.op = qea_pkg::scale_op(step_q);
					qea_pkg::CMD_EVAL:  ctl.op = qea_pkg::eval_op(step_q);
					default:            ctl.op = '0;
				endcase
				if (step_q == last_step) begin
					state_d = qea_pkg::ST_DRAIN;
				end
			end
			qea_pkg::ST_DRAIN: begin
				// last accumulate lands this cycle
				if (cmd_q == qea_pkg::CMD_EVAL) begin
					state_d = qea_pkg::ST_FINISH;
				end else begin
					state_d = qea_pkg::ST_IDLE;
				end
			end
			qea_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = qea_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = qea_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/qea_dp.sv -----
// datapath of the quadric error accumulator: coefficients, shared multiplier, accumulators
`timescale 1ns / 1ps

module qea_dp #(
	parameter int FRAC_BITS   = 12,
	parameter int COEFF_WIDTH = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  qea_pkg::ctl_t                        ctl,
	output qea_pkg::sts_t                        sts,
	input  logic signed [qea_pkg::PLANE_W-1:0]  plane_a,
	input  logic signed [qea_pkg::PLANE_W-1:0]  plane_b,
	input  logic signed [qea_pkg::PLANE_W-1:0]  plane_c,
	input  logic signed [qea_pkg::PLANE_W-1:0]  plane_d,
	input  logic signed [qea_pkg::WEIGHT_W-1:0] plane_weight,
	input  logic signed [qea_pkg::POINT_W-1:0]  point_x,
	input  logic signed [qea_pkg::POINT_W-1:0]  point_y,
	input  logic signed [qea_pkg::POINT_W-1:0]  point_z,
	input  logic signed [qea_pkg::SCALE_W-1:0]  scale_factor,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [qea_pkg::ERR_W-1:0]    error_value,
	output logic signed [qea_pkg::SUM_W-1:0]    weight_sum
);

	localparam int CW  = COEFF_WIDTH;
	localparam int BW  = qea_pkg::MUL_B_W;
	localparam int PW  = CW + BW;
	localparam int EW  = (CW > qea_pkg::ERR_W) ? CW : qea_pkg::ERR_W;
	localparam int SW  = qea_pkg::SUM_W;
	localparam int SSW = SW + 2;

	localparam logic signed [BW-1:0] ONE    = BW'(1 << FRAC_BITS);
	localparam logic signed [CW-1:0] CW_MAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic signed [CW-1:0] CW_MIN = {1'b1, {(CW - 1){1'b0}}};
	localparam logic signed [SW-1:0] SW_MAX = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] SW_MIN = {1'b1, {(SW - 1){1'b0}}};
	localparam logic signed [qea_pkg::ERR_W-1:0] ERR_MAX = {1'b0, {(qea_pkg::ERR_W - 1){1'b1}}};
	localparam logic signed [qea_pkg::ERR_W-1:0] ERR_MIN = {1'b1, {(qea_pkg::ERR_W - 1){1'b0}}};

	// item registers
	logic signed [BW-1:0]                 pa_q, pb_q, pc_q, pd_q;
	logic signed [qea_pkg::WEIGHT_W-1:0]  w_q;
	logic signed [BW-1:0]                 x_q, y_q, z_q, s_q;

	// state
	logic signed [CW-1:0]                 coef_q [qea_pkg::NUM_COEFF];
	logic signed [SW-1:0]                 weight_q;
	logic signed [CW-1:0]                 acc_x_q, acc_y_q, acc_z_q;

	// issue side
	logic signed [CW-1:0]                 coef_rd;
	logic signed [CW-1:0]                 a_val;
	logic signed [BW-1:0]                 b_val;
	logic signed [PW-1:0]                 prod;
	logic signed [SSW-1:0]                weight_sum_d;

	// accumulate stage
	qea_pkg::op_t                         op_s1;
	logic signed [PW-1:0]                 prod_s1;
	logic signed [CW-1:0]                 base_s1;
	logic signed [PW-1:0]                 shifted;
	logic signed [CW-1:0]                 term;
	logic signed [PW-1:0]                 addend;
	logic signed [CW-1:0]                 base;
	logic signed [CW-1:0]                 acc_res;

	// result register
	logic                                 out_vld_q;
	logic signed [qea_pkg::ERR_W-1:0]    err_q;
	logic signed [SW-1:0]                 wsum_q;

	function automatic logic signed [CW-1:0] sat_cw(input logic signed [PW-1:0] v);
		logic [PW-CW:0] top;
		top = v[PW-1:CW-1];
		if ((&top) || !(|top)) begin
			return v[CW-1:0];
		end else if (v[PW-1]) begin
			return CW_MIN;
		end else begin
			return CW_MAX;
		end
	endfunction

	function automatic logic signed [SW-1:0] sat_sw(input logic signed [SSW-1:0] v);
		logic [SSW-SW:0] top;
		top = v[SSW-1:SW-1];
		if ((&top) || !(|top)) begin
			return v[SW-1:0];
		end else if (v[SSW-1]) begin
			return SW_MIN;
		end else begin
			return SW_MAX;
		end
	endfunction

	function automatic logic signed [qea_pkg::ERR_W-1:0] sat_err(input logic signed [EW-1:0] v);
		logic [EW-qea_pkg::ERR_W:0] top;
		top = v[EW-1:qea_pkg::ERR_W-1];
		if ((&top) || !(|top)) begin
			return v[qea_pkg::ERR_W-1:0];
		end else if (v[EW-1]) begin
			return ERR_MIN;
		end else begin
			return ERR_MAX;
		end
	endfunction

	function automatic logic signed [BW-1:0] pick_plane(input logic [1:0] idx);
		case (idx)
			2'd0:    return pa_q;
			2'd1:    return pb_q;
			2'd2:    return pc_q;
			default: return pd_q;
		endcase
	endfunction

	function automatic logic signed [CW-1:0] pick_acc(input qea_pkg::acc_t sel);
		case (sel)
			qea_pkg::ACC_X: return acc_x_q;
			qea_pkg::ACC_Y: return acc_y_q;
			qea_pkg::ACC_Z: return acc_z_q;
			default:        return acc_x_q;
		endcase
	endfunction

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			pa_q <= plane_a;
			pb_q <= plane_b;
			pc_q <= plane_c;
			pd_q <= plane_d;
			w_q  <= plane_weight;
			x_q  <= point_x;
			y_q  <= point_y;
			z_q  <= point_z;
			s_q  <= scale_factor;
		end
	end

	// operand select
	assign coef_rd = coef_q[ctl.op.rd_idx];

	always_comb begin
		case (ctl.op.asel)
			qea_pkg::ASEL_PLANE: a_val = CW'(pick_plane(ctl.op.a_pln));
			qea_pkg::ASEL_ACC:   a_val = pick_acc(ctl.op.a_acc);
			default:             a_val = coef_rd;
		endcase
	end

	always_comb begin
		case (ctl.op.bsel)
			qea_pkg::BSEL_X:     b_val = x_q;
			qea_pkg::BSEL_Y:     b_val = y_q;
			qea_pkg::BSEL_Z:     b_val = z_q;
			qea_pkg::BSEL_SCALE: b_val = s_q;
			qea_pkg::BSEL_PLANE: b_val = pick_plane(ctl.op.b_pln);
			default:             b_val = ONE;
		endcase
	end

	// shared multiplier, registered
	assign prod = a_val * b_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= ctl.op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		base_s1 <= coef_rd;
	end

	// floor shift, saturate, negate or double, then saturating add
	always_comb begin
		shifted = op_s1.shift ? (prod_s1 >>> FRAC_BITS) : prod_s1;
		term    = sat_cw(shifted);
		if (op_s1.dbl) begin
			addend = PW'(sat_cw(PW'(term) + PW'(term)));
		end else if (op_s1.neg) begin
			addend = -PW'(term);
		end else begin
			addend = PW'(term);
		end
		if (op_s1.load) begin
			base = '0;
		end else if (op_s1.to_coef) begin
			base = base_s1;
		end else begin
			base = pick_acc(op_s1.dst);
		end
		acc_res = sat_cw(PW'(base) + addend);
	end

	// coefficient store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qea_pkg::NUM_COEFF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			for (int i = 0; i < qea_pkg::NUM_COEFF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (op_s1.vld && op_s1.to_coef) begin
			coef_q[op_s1.rd_idx] <= acc_res;
		end
	end

	// partial sums
	always_ff @(posedge clk) begin
		if (op_s1.vld && !op_s1.to_coef) begin
			case (op_s1.dst)
				qea_pkg::ACC_Y: acc_y_q <= acc_res;
				qea_pkg::ACC_Z: acc_z_q <= acc_res;
				default:        acc_x_q <= acc_res;
			endcase
		end
	end

	// weight total
	always_comb begin
		if (ctl.op.wgt_sub) begin
			weight_sum_d = SSW'(weight_q) - SSW'(w_q);
		end else begin
			weight_sum_d = SSW'(weight_q) + SSW'(w_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
		end else if (ctl.clear) begin
			weight_q <= '0;
		end else if (ctl.op.vld && (ctl.op.wgt_add || ctl.op.wgt_sub)) begin
			weight_q <= sat_sw(weight_sum_d);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			err_q  <= sat_err(EW'(acc_x_q));
			wsum_q <= weight_q;
		end
	end

	assign sts.out_free = !out_vld_q || out_ready;
	assign out_valid    = out_vld_q;
	assign error_value  = err_q;
	assign weight_sum   = wsum_q;

endmodule

// ----- hw/rtl/qea_chk.sv -----
// port-level checks of the quadric error accumulator and their binding
`timescale 1ns / 1ps

module qea_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [qea_pkg::CMD_W-1:0]         in_command,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [qea_pkg::ERR_W-1:0] error_value,
	input logic signed [qea_pkg::SUM_W-1:0] weight_sum
);

	// a waiting result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(error_value) && $stable(weight_sum))
		else $error("result changed while stalled");

	// an evaluate item keeps the block busy
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_command == qea_pkg::CMD_EVAL |=> !in_ready)
		else $error("ready right after evaluate item");

	// clear and unknown commands leave the block ready
	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_command == qea_pkg::CMD_CLEAR ||
			in_command > qea_pkg::CMD_EVAL) |=> in_ready)
		else $error("clear or unknown command stalled the block");

	// a new result only comes out of a busy block
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while block was idle");

endmodule

bind quadric_error_accumulator qea_chk u_qea_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (cmd.valid),
	.in_ready    (cmd.ready),
	.in_command  (cmd.command),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.error_value (result.error_value),
	.weight_sum  (result.weight_sum)
);
